[rtl/core/tcw_pkg.sv]
// shared types, constants and payload structs for the text console writer
// depends on nothing; used by every module of the block

package tcw_pkg;

   // default screen geometry
   localparam int COLUMNS_DEFAULT = 80;
   localparam int ROWS_DEFAULT    = 25;

   // depth of the queues between the parts of the block
   localparam int QUEUE_DEPTH = 2;

   // character and cell codes
   localparam logic [7:0]  NEWLINE_CODE = 8'h0A;
   localparam logic [7:0]  SPACE_CODE   = 8'h20;
   localparam logic [15:0] RESET_CELL   = 16'h0720;
   localparam logic [7:0]  RESET_COLOR  = 8'h07;

   // command codes on the request channel
   localparam logic CMD_PUT  = 1'b0;
   localparam logic CMD_READ = 1'b1;

   // request beat
   typedef struct packed {
      logic       cmd;
      logic [7:0] char_code;
      logic [4:0] read_row;
      logic [6:0] read_col;
   } req_payload_type;

   // result beat
   typedef struct packed {
      logic [15:0] cell_value;
      logic [4:0]  cursor_row;
      logic [6:0]  cursor_col;
      logic        scrolled;
   } rsp_payload_type;

   // classified command kinds
   typedef enum logic [1:0] {
      KIND_PUT,
      KIND_NEWLINE,
      KIND_READ,
      KIND_READ_SKIP
   } cmd_kind_type;

   // one entry of the command queue
   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   char_code;
      logic [4:0]   read_row;
      logic [6:0]   read_col;
   } cmd_entry_type;

   // front to executor: head of the command queue
   typedef struct packed {
      logic          valid;
      cmd_entry_type entry;
   } cmd_beat_type;

   // executor to front: dequeue and busy
   typedef struct packed {
      logic pop;
      logic busy;
   } exec_status_type;

   // executor to result queue
   typedef struct packed {
      logic            push;
      rsp_payload_type payload;
   } rsp_beat_type;

endpackage

[rtl/core/text_console_writer.sv]
// top level of the text console writer: front end, executor, result queue
// depends on tcw_pkg, tcw_front, tcw_exec and tcw_rsp_queue
//
//   channel   ports                          handshake
//   request   req_push req_full req_payload  beat taken on push and not full
//   result    rsp_pop rsp_empty rsp_payload  beat taken on pop and not empty
//   config    csr_wr_en csr_wr_data          text color written on wr_en
//
// after reset the store is swept to grey-on-black spaces,
// with req_full held high; color writes are taken during the sweep
// a put or newline is done in ST_IDLE, a read also in ST_READ (registered read)
// a scroll moves a circular top-row pointer and blanks one row in ST_CLEAR
// both sides hold two beats in queues, so each can stall on its own

module text_console_writer #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   output logic                     req_full,
   input  tcw_pkg::req_payload_type req_payload,
   input  logic                     rsp_pop,
   output logic                     rsp_empty,
   output tcw_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_wr_en,
   input  logic [7:0]               csr_wr_data
);

   tcw_pkg::cmd_beat_type    cmd_beat;
   tcw_pkg::exec_status_type exec_status;
   tcw_pkg::rsp_beat_type    rsp_beat;
   logic                     rsp_full;

   // accept and classify
   tcw_front #(
      .COLUMNS(COLUMNS),
      .ROWS   (ROWS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_payload(req_payload),
      .exec_status(exec_status),
      .cmd_beat   (cmd_beat)
   );

   // carry out commands on the screen store
   tcw_exec #(
      .COLUMNS(COLUMNS),
      .ROWS   (ROWS)
   ) u_exec (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .cmd_beat   (cmd_beat),
      .exec_status(exec_status),
      .rsp_full   (rsp_full),
      .rsp_beat   (rsp_beat)
   );

   // hold results for the consumer
   tcw_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .rsp_beat   (rsp_beat),
      .rsp_full   (rsp_full),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_payload(rsp_payload)
   );

endmodule

[rtl/core/tcw_front.sv]
// front end: accepts request beats, classifies them and queues them
// depends on tcw_pkg

module tcw_front #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   output logic                     req_full,
   input  tcw_pkg::req_payload_type req_payload,
   input  tcw_pkg::exec_status_type exec_status,
   output tcw_pkg::cmd_beat_type    cmd_beat
);

   localparam int DEPTH = tcw_pkg::QUEUE_DEPTH;
   localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW  = $clog2(DEPTH + 1);

   tcw_pkg::cmd_entry_type entries_ff [DEPTH];
   tcw_pkg::cmd_entry_type new_entry;
   logic [PW-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]        count_ff, count_in;
   logic                   do_push, do_pop;
   logic                   in_range;

   // classify the incoming beat
   always_comb begin
      in_range = (32'(req_payload.read_row) < 32'(ROWS)) &&
                 (32'(req_payload.read_col) < 32'(COLUMNS));
      new_entry.char_code = req_payload.char_code;
      new_entry.read_row  = req_payload.read_row;
      new_entry.read_col  = req_payload.read_col;
      if (req_payload.cmd == tcw_pkg::CMD_READ) begin
         new_entry.kind = in_range ? tcw_pkg::KIND_READ : tcw_pkg::KIND_READ_SKIP;
      end else if (req_payload.char_code == tcw_pkg::NEWLINE_CODE) begin
         new_entry.kind = tcw_pkg::KIND_NEWLINE;
      end else begin
         new_entry.kind = tcw_pkg::KIND_PUT;
      end
   end

   // queue control
   always_comb begin
      req_full  = (count_ff == CNTW'(DEPTH)) || exec_status.busy;
      do_push   = req_push && !req_full;
      do_pop    = exec_status.pop && (count_ff != '0);
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
      cmd_beat.valid = (count_ff != '0);
      cmd_beat.entry = entries_ff[rd_ptr_ff];
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= new_entry;
      end
   end

endmodule

[rtl/core/tcw_exec.sv]
// back end: cursor, scroll and screen store sequencer
// depends on tcw_pkg; takes commands from tcw_front, feeds tcw_rsp_queue

module tcw_exec #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [7:0]               csr_wr_data,
   input  tcw_pkg::cmd_beat_type    cmd_beat,
   output tcw_pkg::exec_status_type exec_status,
   input  logic                     rsp_full,
   output tcw_pkg::rsp_beat_type    rsp_beat
);

   localparam int DEPTH = ROWS * COLUMNS;
   localparam int AW    = $clog2(DEPTH);
   localparam int RW    = $clog2(ROWS);
   localparam int CW    = $clog2(COLUMNS);

   typedef enum logic [1:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ,
      ST_CLEAR
   } state_type;

   state_type     state_ff, state_in;
   logic [RW-1:0] cur_row_ff, cur_row_in;
   logic [CW-1:0] cur_col_ff, cur_col_in;
   logic [RW-1:0] top_ff, top_in;
   logic [RW-1:0] clear_row_ff, clear_row_in;
   logic [AW-1:0] count_ff, count_in;
   logic [7:0]    color_ff, color_in;

   logic [15:0]   mem [DEPTH];
   logic [15:0]   rd_data_ff;
   logic          mem_we, mem_re;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [15:0]   mem_wdata;

   logic          take;
   logic          wrap;
   tcw_pkg::cmd_entry_type cmd;

   // logical row to physical row of the circular store
   function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] top,
                                              input logic [RW-1:0] row);
      logic [RW:0] sum;
      sum = {1'b0, top} + {1'b0, row};
      if (sum >= (RW+1)'(ROWS)) begin
         sum = sum - (RW+1)'(ROWS);
      end
      return sum[RW-1:0];
   endfunction

   // physical row and column to store address
   function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] prow,
                                               input logic [CW-1:0] col);
      return AW'(32'(prow) * COLUMNS + 32'(col));
   endfunction

   // sequencer next state and store access
   always_comb begin
      cmd          = cmd_beat.entry;
      state_in     = state_ff;
      cur_row_in   = cur_row_ff;
      cur_col_in   = cur_col_ff;
      top_in       = top_ff;
      clear_row_in = clear_row_ff;
      count_in     = count_ff;
      color_in     = csr_wr_en ? csr_wr_data : color_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_waddr    = '0;
      mem_raddr    = '0;
      mem_wdata    = '0;
      take         = 1'b0;
      wrap         = 1'b0;
      rsp_beat.push                = 1'b0;
      rsp_beat.payload.cell_value  = '0;
      rsp_beat.payload.scrolled    = 1'b0;
      case (state_ff)
         // sweep the whole store to grey-on-black spaces
         ST_INIT: begin
            mem_we    = 1'b1;
            mem_waddr = count_ff;
            mem_wdata = tcw_pkg::RESET_CELL;
            count_in  = count_ff + 1'b1;
            if (count_ff == AW'(DEPTH - 1)) begin
               count_in = '0;
               state_in = ST_IDLE;
            end
         end
         // dispatch one command
         ST_IDLE: begin
            take = cmd_beat.valid && !rsp_full;
            if (take) begin
               case (cmd.kind)
                  tcw_pkg::KIND_PUT: begin
                     mem_we    = 1'b1;
                     mem_waddr = cell_addr(phys_row(top_ff, cur_row_ff), cur_col_ff);
                     mem_wdata = {color_ff, cmd.char_code};
                     if (cur_col_ff == CW'(COLUMNS - 1)) begin
                        wrap = 1'b1;
                     end else begin
                        cur_col_in    = cur_col_ff + 1'b1;
                        rsp_beat.push = 1'b1;
                     end
                  end
                  tcw_pkg::KIND_NEWLINE: begin
                     wrap = 1'b1;
                  end
                  tcw_pkg::KIND_READ: begin
                     mem_re    = 1'b1;
                     mem_raddr = cell_addr(phys_row(top_ff, RW'(cmd.read_row)),
                                           CW'(cmd.read_col));
                     state_in  = ST_READ;
                  end
                  tcw_pkg::KIND_READ_SKIP: begin
                     rsp_beat.push = 1'b1;
                  end
                  default: begin
                     rsp_beat.push = 1'b1;
                  end
               endcase
               // newline or wrap at the last column: next row, or scroll on the last row
               if (wrap) begin
                  cur_col_in = '0;
                  if (cur_row_ff == RW'(ROWS - 1)) begin
                     clear_row_in = top_ff;
                     top_in       = (top_ff == RW'(ROWS - 1)) ? '0 : top_ff + 1'b1;
                     count_in     = '0;
                     state_in     = ST_CLEAR;
                  end else begin
                     cur_row_in    = cur_row_ff + 1'b1;
                     rsp_beat.push = 1'b1;
                  end
               end
            end
         end
         // registered read data is ready
         ST_READ: begin
            rsp_beat.push               = 1'b1;
            rsp_beat.payload.cell_value = rd_data_ff;
            state_in                    = ST_IDLE;
         end
         // blank the new bottom row one cell a cycle
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = cell_addr(clear_row_ff, count_ff[CW-1:0]);
            mem_wdata = {color_ff, tcw_pkg::SPACE_CODE};
            count_in  = count_ff + 1'b1;
            if (count_ff[CW-1:0] == CW'(COLUMNS - 1)) begin
               count_in                  = '0;
               rsp_beat.push             = 1'b1;
               rsp_beat.payload.scrolled = 1'b1;
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_beat.payload.cursor_row = 5'(cur_row_in);
      rsp_beat.payload.cursor_col = 7'(cur_col_in);
      exec_status.pop  = take;
      exec_status.busy = (state_ff == ST_INIT);
   end

   // state, cursor and scroll registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         top_ff       <= '0;
         clear_row_ff <= '0;
         count_ff     <= '0;
         color_ff     <= tcw_pkg::RESET_COLOR;
      end else begin
         state_ff     <= state_in;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         top_ff       <= top_in;
         clear_row_ff <= clear_row_in;
         count_ff     <= count_in;
         color_ff     <= color_in;
      end
   end

   // screen store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

endmodule

[rtl/core/tcw_rsp_queue.sv]
// result queue between the executor and the result channel
// depends on tcw_pkg

module tcw_rsp_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  tcw_pkg::rsp_beat_type    rsp_beat,
   output logic                     rsp_full,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output tcw_pkg::rsp_payload_type rsp_payload
);

   localparam int DEPTH = tcw_pkg::QUEUE_DEPTH;
   localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW  = $clog2(DEPTH + 1);

   tcw_pkg::rsp_payload_type entries_ff [DEPTH];
   logic [PW-1:0]            wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]            rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]          count_ff, count_in;
   logic                     do_push, do_pop;

   // queue control
   always_comb begin
      rsp_full    = (count_ff == CNTW'(DEPTH));
      rsp_empty   = (count_ff == '0);
      do_push     = rsp_beat.push && !rsp_full;
      do_pop      = rsp_pop && !rsp_empty;
      wr_ptr_in   = wr_ptr_ff;
      rd_ptr_in   = rd_ptr_ff;
      count_in    = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
      rsp_payload = entries_ff[rd_ptr_ff];
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= rsp_beat.payload;
      end
   end

endmodule
